/* sv/framed_packet_decoder_crc16_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet decoder
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_DECODER_CRC16_MACROS_SVH
`define FRAMED_PACKET_DECODER_CRC16_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/fpdc_pkg.sv */
// ----------------------------------------------------------------------------
// Framed packet decoder package
// Result codes, register indexes, control and status bundles, CRC step.
// ----------------------------------------------------------------------------
package fpdc_pkg;

	// Result status codes carried on tuser.
	localparam logic [1:0] ST_MORE = 2'd0;
	localparam logic [1:0] ST_GOOD = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;
	localparam logic [1:0] ST_CRC  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAX_LEN      = 2'd0;
	localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd1;
	localparam logic [1:0] CFG_MAGIC_SECOND = 2'd2;

	// Register reset values.
	localparam logic [6:0] MAX_LEN_RST      = 7'd64;
	localparam logic [7:0] MAGIC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] MAGIC_SECOND_RST = 8'h55;

	// CRC-16/CCITT-FALSE constants.
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       out_single;
		logic [1:0] out_status;
		logic       out_replay;
		logic       crc_init;
		logic       crc_upd;
		logic       ld_type;
		logic       ld_seq;
		logic       ld_len_hi;
		logic       ld_len;
		logic       ld_crc_hi;
		logic       st_wr;
		logic       frame_clr;
		logic       frame_end;
		logic       rep_clr;
		logic       rep_inc;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match_first;
		logic match_second;
		logic len_bad;
		logic len_zero;
		logic stored_last;
		logic crc_ok;
		logic held_len_zero;
		logic rep_last;
		logic out_free;
	} sts_t;

	// One byte of the MSB-first CRC, eight shift steps.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* sv/fpdc_ctrl.sv */
// ----------------------------------------------------------------------------
// Framed packet decoder controller
// Frame phase state machine and replay sequencing; drives datapath commands.
// ----------------------------------------------------------------------------
`include "framed_packet_decoder_crc16_macros.svh"

module fpdc_ctrl
	import fpdc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_M0      = 4'd0;
	localparam logic [3:0] S_M1      = 4'd1;
	localparam logic [3:0] S_TYPE    = 4'd2;
	localparam logic [3:0] S_SEQ     = 4'd3;
	localparam logic [3:0] S_LEN_HI  = 4'd4;
	localparam logic [3:0] S_LEN_LO  = 4'd5;
	localparam logic [3:0] S_PAYLOAD = 4'd6;
	localparam logic [3:0] S_CRC_HI  = 4'd7;
	localparam logic [3:0] S_CRC_LO  = 4'd8;
	localparam logic [3:0] S_RD      = 4'd9;
	localparam logic [3:0] S_EMIT    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rx_state;
	logic       accept;

	// The receive phases occupy the codes up to the low CRC byte.
	assign rx_state = (state_q <= S_CRC_LO);

	// A byte is taken in any receive phase once the output register is free.
	assign s_tready = rx_state && sts.out_free;
	assign accept   = s_tvalid && s_tready;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		unique case (state_q)
			S_M0: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					if (sts.match_first) begin
						state_d = S_M1;
					end
				end
			end
			S_M1: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					if (sts.match_second) begin
						cmd.crc_init = 1'b1;
						state_d      = S_TYPE;
					end else if (!sts.match_first) begin
						state_d = S_M0;
					end
				end
			end
			S_TYPE: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					cmd.ld_type    = 1'b1;
					cmd.crc_upd    = 1'b1;
					state_d        = S_SEQ;
				end
			end
			S_SEQ: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					cmd.ld_seq     = 1'b1;
					cmd.crc_upd    = 1'b1;
					state_d        = S_LEN_HI;
				end
			end
			S_LEN_HI: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					cmd.ld_len_hi  = 1'b1;
					cmd.crc_upd    = 1'b1;
					state_d        = S_LEN_LO;
				end
			end
			S_LEN_LO: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.crc_upd    = 1'b1;
					if (sts.len_bad) begin
						cmd.out_status = ST_LEN;
						cmd.frame_clr  = 1'b1;
						state_d        = S_M0;
					end else begin
						cmd.out_status = ST_MORE;
						cmd.ld_len     = 1'b1;
						state_d        = sts.len_zero ? S_CRC_HI : S_PAYLOAD;
					end
				end
			end
			S_PAYLOAD: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					cmd.st_wr      = 1'b1;
					cmd.crc_upd    = 1'b1;
					if (sts.stored_last) begin
						state_d = S_CRC_HI;
					end
				end
			end
			S_CRC_HI: begin
				if (accept) begin
					cmd.out_single = 1'b1;
					cmd.out_status = ST_MORE;
					cmd.ld_crc_hi  = 1'b1;
					state_d        = S_CRC_LO;
				end
			end
			S_CRC_LO: begin
				if (accept) begin
					if (!sts.crc_ok) begin
						cmd.out_single = 1'b1;
						cmd.out_status = ST_CRC;
						cmd.frame_clr  = 1'b1;
						state_d        = S_M0;
					end else if (sts.held_len_zero) begin
						cmd.out_single = 1'b1;
						cmd.out_status = ST_GOOD;
						cmd.frame_end  = 1'b1;
						state_d        = S_M0;
					end else begin
						cmd.frame_end = 1'b1;
						cmd.rep_clr   = 1'b1;
						state_d       = S_RD;
					end
				end
			end
			S_RD: begin
				// Store read data settles in this cycle.
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_replay = 1'b1;
					cmd.rep_inc    = 1'b1;
					state_d        = sts.rep_last ? S_M0 : S_RD;
				end
			end
			default: begin
				state_d = S_M0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_M0;
		end else begin
			state_q <= state_d;
		end
	end

	`FPDC_ASSERT_NEXT(a_rd_then_emit, state_q == S_RD, state_q == S_EMIT,
		"replay read not followed by emit")
	`FPDC_ASSERT_NEXT(a_emit_loops, (state_q == S_EMIT) && sts.out_free && !sts.rep_last,
		state_q == S_RD, "replay stopped before the last stored byte")
	`FPDC_ASSERT_NEXT(a_payload_stays,
		accept && (state_q == S_PAYLOAD) && !sts.stored_last,
		state_q == S_PAYLOAD, "payload phase left before length reached")

endmodule

/* sv/fpdc_dp.sv */
// ----------------------------------------------------------------------------
// Framed packet decoder datapath
// Configuration, header fields, running CRC, payload store and result register.
// ----------------------------------------------------------------------------
`include "framed_packet_decoder_crc16_macros.svh"

module fpdc_dp
	import fpdc_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [7:0]  rx_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int         AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] LIMIT = 8'(MAX_PAYLOAD);

	logic [6:0]  max_len_q;
	logic [7:0]  magic_first_q;
	logic [7:0]  magic_second_q;
	logic [7:0]  type_q;
	logic [7:0]  seq_q;
	logic [7:0]  len_hi_q;
	logic [6:0]  len_q;
	logic [7:0]  crc_hi_q;
	logic [15:0] crc_q;
	logic [5:0]  cnt_q;
	logic [5:0]  rep_q;
	logic [7:0]  mem [MAX_PAYLOAD];
	logic [7:0]  rd_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [7:0]  out_type_q;
	logic [7:0]  out_seq_q;
	logic [6:0]  out_len_q;
	logic [7:0]  out_byte_q;
	logic [5:0]  out_idx_q;
	logic        out_last_q;
	logic        good;

	// Status toward the controller.
	always_comb begin
		sts.match_first   = (rx_byte == magic_first_q);
		sts.match_second  = (rx_byte == magic_second_q);
		sts.len_bad       = (len_hi_q != 8'd0) || (rx_byte > {1'b0, max_len_q}) ||
			(rx_byte > LIMIT);
		sts.len_zero      = (len_hi_q == 8'd0) && (rx_byte == 8'd0);
		sts.stored_last   = (7'({1'b0, cnt_q} + 7'd1) == len_q);
		sts.crc_ok        = ({crc_hi_q, rx_byte} == crc_q);
		sts.held_len_zero = (len_q == 7'd0);
		sts.rep_last      = (7'({1'b0, rep_q} + 7'd1) == len_q);
		sts.out_free      = !out_valid_q || m_tready;
	end

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q      <= MAX_LEN_RST;
			magic_first_q  <= MAGIC_FIRST_RST;
			magic_second_q <= MAGIC_SECOND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_LEN:      max_len_q      <= cfg_data[6:0];
				CFG_MAGIC_FIRST:  magic_first_q  <= cfg_data;
				CFG_MAGIC_SECOND: magic_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Header fields, CRC and byte counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= 8'd0;
			seq_q    <= 8'd0;
			len_hi_q <= 8'd0;
			len_q    <= 7'd0;
			crc_hi_q <= 8'd0;
			crc_q    <= CRC_INIT;
			cnt_q    <= 6'd0;
			rep_q    <= 6'd0;
		end else begin
			if (cmd.frame_clr) begin
				type_q   <= 8'd0;
				seq_q    <= 8'd0;
				len_hi_q <= 8'd0;
				len_q    <= 7'd0;
			end else begin
				if (cmd.ld_type) begin
					type_q <= rx_byte;
				end
				if (cmd.ld_seq) begin
					seq_q <= rx_byte;
				end
				if (cmd.ld_len_hi) begin
					len_hi_q <= rx_byte;
				end
				if (cmd.ld_len) begin
					len_q <= rx_byte[6:0];
				end
			end
			if (cmd.frame_clr || cmd.frame_end || cmd.crc_init) begin
				crc_q <= CRC_INIT;
			end else if (cmd.crc_upd) begin
				crc_q <= crc16_byte(crc_q, rx_byte);
			end
			if (cmd.frame_clr || cmd.frame_end) begin
				crc_hi_q <= 8'd0;
			end else if (cmd.ld_crc_hi) begin
				crc_hi_q <= rx_byte;
			end
			if (cmd.frame_clr || cmd.frame_end || cmd.ld_len) begin
				cnt_q <= 6'd0;
			end else if (cmd.st_wr) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (cmd.rep_clr) begin
				rep_q <= 6'd0;
			end else if (cmd.rep_inc) begin
				rep_q <= rep_q + 6'd1;
			end
		end
	end

	// Payload store: written while receiving, read during replay.
	always_ff @(posedge clk) begin
		if (cmd.st_wr) begin
			mem[cnt_q[AW-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rep_q[AW-1:0]];
	end

	assign good = (cmd.out_status == ST_GOOD);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_single || cmd.out_replay) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_single) begin
			out_status_q <= cmd.out_status;
			out_type_q   <= good ? type_q : 8'd0;
			out_seq_q    <= good ? seq_q : 8'd0;
			out_len_q    <= 7'd0;
			out_byte_q   <= 8'd0;
			out_idx_q    <= 6'd0;
			out_last_q   <= 1'b1;
		end else if (cmd.out_replay) begin
			out_status_q <= ST_GOOD;
			out_type_q   <= type_q;
			out_seq_q    <= seq_q;
			out_len_q    <= len_q;
			out_byte_q   <= rd_q;
			out_idx_q    <= rep_q;
			out_last_q   <= sts.rep_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_idx_q, out_byte_q, out_len_q, out_seq_q, out_type_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	`FPDC_ASSERT_NOW(a_err_single, m_tvalid && (m_tuser != ST_GOOD),
		m_tlast && (m_tdata == 40'd0), "non-good result not a bare last beat")
	`FPDC_ASSERT_NOW(a_replay_len, m_tvalid && (m_tuser == ST_GOOD) && !m_tlast,
		m_tdata[22:16] != 7'd0, "replay beat without a payload length")
	`FPDC_ASSERT_NEXT(a_load_valid, cmd.out_single || cmd.out_replay, m_tvalid,
		"loaded result not presented")

endmodule

/* sv/framed_packet_decoder_crc16.sv */
// ----------------------------------------------------------------------------
// Framed packet decoder with CRC-16 check
// Byte stream frame receiver: sync hunt, header capture, CRC and replay.
// ----------------------------------------------------------------------------
// Usage
//   Received bytes enter on the s_ group, one byte per beat. Every byte gives
//   one result beat on the m_ group with status need-more, good, length error
//   or CRC error (tlast set), except the final CRC byte of a good frame with a
//   payload, which gives one beat per stored payload byte, tlast on the last.
//   Configuration writes on the cfg_ channel are taken at any time; issue
//   them only while the decoder is idle.
// Timing
//   A byte's result is presented the cycle after it is accepted, so bytes
//   stream at one per cycle while the receiver keeps taking results; the
//   single result register is what limits input to one byte in flight.
//   Replay of a good frame alternates a read state, which waits on the
//   registered read of the payload store, and an emit state for each payload
//   byte; input is held off until the last replay beat has been loaded.
// Reset and stall
//   Reset restores the register defaults and starts hunting for the first
//   sync byte; the payload store is not cleared. While the receiver stalls,
//   the pending result holds and no further byte is accepted.
// ----------------------------------------------------------------------------
module framed_packet_decoder_crc16
	import fpdc_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Received bytes.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] frame_type, [15:8] frame_seq, [22:16] frame_len,
	// [30:23] payload_byte, [36:31] byte_index, [39:37] zero
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // last
);

	cmd_t cmd;
	sts_t sts;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	fpdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpdc_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the framed packet decoder with CRC-16 check
// Drives byte beats and register writes with random idling on both sides,
// predicts every result beat with an independent decoder model held in a
// scoreboard, and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import fpdc_pkg::*;

	localparam int PAYLOAD_CAP = 64;
	// Index with no register behind it; a write there must change nothing.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// Decoder phases of the predictor.
	typedef enum logic [3:0] {
		HUNT_FIRST, HUNT_SECOND, GET_TYPE, GET_SEQ, GET_LEN_HI, GET_LEN_LO,
		GET_PAYLOAD, GET_CRC_HI, GET_CRC_LO
	} rx_phase_e;

	// One result beat, unpacked.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] ftype;
		logic [7:0] fseq;
		logic [6:0] flen;
		logic [7:0] payload;
		logic [5:0] pos;
		logic       last;
	} frame_result_t;

	// Scoreboard: its own copy of the decoder state and registers, and the
	// result beats still owed by the block.
	class frame_checker;
		logic [6:0]    max_len;
		logic [7:0]    magic_a;
		logic [7:0]    magic_b;
		rx_phase_e     phase;
		logic [7:0]    hold_type;
		logic [7:0]    hold_seq;
		logic [15:0]   hold_len;
		logic [6:0]    stored;
		logic [15:0]   run_crc;
		logic [15:0]   rx_crc;
		logic [7:0]    store [PAYLOAD_CAP];
		frame_result_t owed_results [$];
		int            errors;

		function new();
			max_len = MAX_LEN_RST;
			magic_a = MAGIC_FIRST_RST;
			magic_b = MAGIC_SECOND_RST;
			errors  = 0;
			clear_frame();
		endfunction

		// CRC-16/CCITT-FALSE, one input bit at a time, MSB first.
		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ d[i];
				c  = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void clear_frame();
			phase     = HUNT_FIRST;
			hold_type = '0;
			hold_seq  = '0;
			hold_len  = '0;
			stored    = '0;
			run_crc   = CRC_INIT;
			rx_crc    = '0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_MAX_LEN:      max_len = val[6:0];
				CFG_MAGIC_FIRST:  magic_a = val;
				CFG_MAGIC_SECOND: magic_b = val;
				default: ;
			endcase
		endfunction

		// Advance the decoder by one accepted byte and queue what it owes.
		function void note_byte(logic [7:0] b);
			frame_result_t r;
			r        = '0;
			r.status = ST_MORE;
			r.last   = 1'b1;
			case (phase)
				HUNT_FIRST: begin
					if (b == magic_a) phase = HUNT_SECOND;
				end
				HUNT_SECOND: begin
					// The second magic byte is tested first, so equal bytes open a frame.
					if (b == magic_b) begin
						phase   = GET_TYPE;
						run_crc = CRC_INIT;
					end else if (b != magic_a) begin
						phase = HUNT_FIRST;
					end
				end
				GET_TYPE: begin
					hold_type = b;
					run_crc   = crc_step(run_crc, b);
					phase     = GET_SEQ;
				end
				GET_SEQ: begin
					hold_seq = b;
					run_crc  = crc_step(run_crc, b);
					phase    = GET_LEN_HI;
				end
				GET_LEN_HI: begin
					hold_len = {b, 8'h00};
					run_crc  = crc_step(run_crc, b);
					phase    = GET_LEN_LO;
				end
				GET_LEN_LO: begin
					hold_len[7:0] = b;
					run_crc       = crc_step(run_crc, b);
					stored        = '0;
					if (hold_len > max_len || hold_len > PAYLOAD_CAP) begin
						clear_frame();
						r.status = ST_LEN;
					end else begin
						phase = (hold_len == 0) ? GET_CRC_HI : GET_PAYLOAD;
					end
				end
				GET_PAYLOAD: begin
					store[stored[5:0]] = b;
					stored  = stored + 7'd1;
					run_crc = crc_step(run_crc, b);
					if (stored >= hold_len) phase = GET_CRC_HI;
				end
				GET_CRC_HI: begin
					rx_crc = {b, 8'h00};
					phase  = GET_CRC_LO;
				end
				GET_CRC_LO: begin
					rx_crc[7:0] = b;
					if (rx_crc != run_crc) begin
						clear_frame();
						r.status = ST_CRC;
					end else begin
						phase   = HUNT_FIRST;
						stored  = '0;
						rx_crc  = '0;
						run_crc = CRC_INIT;
						r.status = ST_GOOD;
						r.ftype  = hold_type;
						r.fseq   = hold_seq;
						// A good frame with a payload replays it, one beat per byte.
						if (hold_len != 0) begin
							for (int k = 0; k < hold_len; k++) begin
								r.flen    = hold_len[6:0];
								r.payload = store[k];
								r.pos     = k[5:0];
								r.last    = (k == hold_len - 1);
								owed_results.push_back(r);
							end
							return;
						end
					end
				end
				default: clear_frame();
			endcase
			owed_results.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compare one result beat with the oldest owed one.
		function void check_beat(frame_result_t got);
			frame_result_t want;
			if (owed_results.size() == 0) begin
				$error("result beat with none owed: status %0d", got.status);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("frame_type", want.ftype, got.ftype);
			compare_field("frame_seq", want.fseq, got.fseq);
			compare_field("frame_len", want.flen, got.flen);
			compare_field("payload_byte", want.payload, got.payload);
			compare_field("byte_index", want.pos, got.pos);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	frame_checker sb;
	logic [7:0]   tx_bytes [$];
	bit           calm = 1'b0;

	framed_packet_decoder_crc16 #(
		.MAX_PAYLOAD(PAYLOAD_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls at random except during the calm stretch.
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 29);
	end

	// Monitor: every handshake is seen at the rising edge.
	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready) begin
				got.status  = m_tuser;
				got.ftype   = m_tdata[7:0];
				got.fseq    = m_tdata[15:8];
				got.flen    = m_tdata[22:16];
				got.payload = m_tdata[30:23];
				got.pos     = m_tdata[36:31];
				got.last    = m_tlast;
				sb.check_beat(got);
			end
			if (s_tvalid && s_tready) sb.note_byte(s_tdata);
		end
	end

	// Send one byte beat; entered and left at a falling edge with tvalid held.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_queued();
		while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
	endtask

	// Hold the sender off until every owed result beat has arrived.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// One register write; the caller lowers cfg_valid after the last one.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [7:0] max_val, input logic [7:0] first,
		input logic [7:0] second);
		drain_results();
		repeat (4) @(negedge clk);
		write_reg(CFG_MAX_LEN, max_val);
		write_reg(CFG_MAGIC_FIRST, first);
		write_reg(CFG_MAGIC_SECOND, second);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int length_limit();
		return (sb.max_len < PAYLOAD_CAP) ? int'(sb.max_len) : PAYLOAD_CAP;
	endfunction

	// Queue a frame under the current magic bytes. A length over the limit
	// stops after the length field; keep cuts the frame short when not negative.
	task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] fseq,
		input logic [15:0] len, input logic [15:0] crc_flip, input int keep);
		logic [7:0]  body [$];
		logic [15:0] crc;
		body = {sb.magic_a, sb.magic_b, ftype, fseq, len[15:8], len[7:0]};
		if (len <= length_limit()) begin
			for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
			crc = CRC_INIT;
			for (int i = 2; i < body.size(); i++) crc = frame_checker::crc_step(crc, body[i]);
			crc = crc ^ crc_flip;
			body.push_back(crc[15:8]);
			body.push_back(crc[7:0]);
		end
		if (keep < 0 || keep > body.size()) keep = body.size();
		for (int i = 0; i < keep; i++) tx_bytes.push_back(body[i]);
	endtask

	// Mostly well-formed frames with random content, the rest broken or noise.
	task automatic random_traffic(input int budget, input bit with_full);
		int queued;
		int frames;
		int lim;
		int len;
		int r;
		queued = 0;
		frames = 0;
		lim    = length_limit();
		if (with_full) begin
			queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'(lim), 16'h0000, -1);
		end
		while (queued < budget) begin
			r   = $urandom_range(0, 99);
			len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, (lim < 8) ? lim : 8)
				: $urandom_range(0, lim);
			if (r < 55) begin
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(len), 16'h0000, -1);
			end else if (r < 67) begin
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(len), 16'($urandom_range(1, 65535)), -1);
			end else if (r < 77) begin
				len = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535);
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(len), 16'h0000, -1);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 3)) tx_bytes.push_back(sb.magic_a);
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(len), 16'h0000, -1);
			end else if (r < 93) begin
				repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(len), 16'h0000, $urandom_range(1, len + 7));
			end
			queued += tx_bytes.size();
			send_queued();
			frames++;
			if (frames % 12 == 11) drain_results();
		end
	endtask

	// Main sequence: reset, directed frames, then random phases under
	// several register settings.
	initial begin
		sb        = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Good frame with an empty payload, type and seq at the extremes.
		queue_frame(8'h00, 8'hFF, 16'd0, 16'h0000, -1);
		// Repeated first magic byte, then a one-byte payload.
		tx_bytes.push_back(sb.magic_a);
		queue_frame(8'hFF, 8'h00, 16'd1, 16'h0000, -1);
		// Largest length field, rejected.
		queue_frame(8'h5A, 8'hA5, 16'hFFFF, 16'h0000, -1);
		send_queued();

		random_traffic(90, 1'b1);

		// Zero length limit, magic bytes at the extremes.
		set_regs(8'h00, 8'h00, 8'hFF);
		random_traffic(30, 1'b0);

		// Limit clamped by the payload capacity, equal magic bytes, no idling.
		calm = 1'b1;
		set_regs(8'hFF, 8'h3C, 8'h3C);
		random_traffic(90, 1'b1);
		calm = 1'b0;

		// Small limit, random magic bytes, and a write to the unused index.
		set_regs(8'd5, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		write_reg(CFG_UNUSED, 8'h01);
		cfg_valid <= 1'b0;
		@(negedge clk);
		random_traffic(40, 1'b0);

		set_regs(8'd64, 8'hFF, 8'h00);
		random_traffic(40, 1'b0);

		drain_results();
		repeat (2 * PAYLOAD_CAP + 20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* framed_packet_decoder_crc16.f */
+incdir+sv
sv/fpdc_pkg.sv
sv/fpdc_ctrl.sv
sv/fpdc_dp.sv
sv/framed_packet_decoder_crc16.sv
verif/tb_top.sv
